[rtl/vnm_pkg.sv]
// Shared types, constants and helper functions for the value-noise marble shader.
package vnm_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int MAX_OCTAVES_DEF    = 8;
  localparam int COS_TABLE_BITS_DEF = 10;

  // Width of the scaled and shifted point in signed Q.20.
  localparam int SPW = 41;

  // Fixed-point one in Q.30.
  localparam logic signed [31:0] ONE30 = 32'sh4000_0000;

  // Lattice hash constants.
  localparam logic [31:0] HASH_YMUL = 32'd400;
  localparam logic [31:0] HASH_ZMUL = 32'd160000;
  localparam logic [31:0] HASH_C1   = 32'd15731;
  localparam logic [31:0] HASH_C2   = 32'd789221;
  localparam logic [31:0] HASH_C3   = 32'd1376312589;

  // pi in unsigned Q.30, used only to build the cosine table.
  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_PERSISTENCE = 3'd0,
    REG_OCTAVES     = 3'd1,
    REG_SHIFT       = 3'd2,
    REG_SCALE       = 3'd3,
    REG_BG          = 3'd4,
    REG_FG          = 3'd5
  } reg_idx_t;

  // Input item: one point in signed Q12.12.
  typedef struct packed {
    logic signed [23:0] z_coord;
    logic signed [23:0] y_coord;
    logic signed [23:0] x_coord;
  } in_item_t;

  // Result item: one shaded color.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } out_item_t;

  // Point handed to each octave lane: sign and magnitude per axis, x at index 0.
  typedef struct packed {
    logic [2:0]           neg;
    logic [2:0][SPW-1:0]  mag;
  } lane_in_t;

  // Cosine of pi*k/2^bits in Q.30 by a truncated Taylor series.
  // Evaluated at elaboration only.
  function automatic logic signed [31:0] cos_entry(input int k, input int bits);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    x   = (PI_Q30 * 64'(k)) >> bits;
    x2  = (x * x) >> 30;
    mag = 64'd1 << 30;
    sum = 64'sd1 <<< 30;
    for (int n = 1; n <= 10; n++) begin
      mag = ((mag * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n % 2) == 1) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    if (sum < -(64'sd1 <<< 30)) begin
      sum = -(64'sd1 <<< 30);
    end
    return 32'(sum);
  endfunction

  // Offset of lattice corner c (bit 0 x, bit 1 y, bit 2 z) in the hash input.
  function automatic logic [31:0] corner_off(input int c);
    logic [31:0] off;
    off = 32'(c & 1);
    if ((c & 2) != 0) begin
      off = off + HASH_YMUL;
    end
    if ((c & 4) != 0) begin
      off = off + HASH_ZMUL;
    end
    return off;
  endfunction

  // First mixing step of the lattice hash.
  function automatic logic [31:0] hash_mix(input logic [31:0] a);
    return (a << 13) ^ a;
  endfunction

  // Difference times weight for one interpolation.
  function automatic logic signed [63:0] blend_prod(input logic signed [31:0] lo,
                                                    input logic signed [31:0] hi,
                                                    input logic [30:0] w);
    logic signed [63:0] d;
    d = 64'(hi) - 64'(lo);
    return d * 64'($signed({1'b0, w}));
  endfunction

  // Low end plus the floored Q.30 product.
  function automatic logic signed [31:0] blend_add(input logic signed [31:0] lo,
                                                   input logic signed [63:0] p);
    return lo + 32'(p >>> 30);
  endfunction

endpackage

[rtl/vnm_cos_rom.sv]
// Cosine table over half a period with a registered read and mirrored upper half.
module vnm_cos_rom #(
  parameter int TABLE_BITS = vnm_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [TABLE_BITS:0]    idx,
  output logic signed [31:0]     cos_val
);
  import vnm_pkg::*;

  localparam int N    = 1 << TABLE_BITS;
  localparam int HALF = N / 2;

  logic signed [31:0]  tab [HALF+1];
  logic [TABLE_BITS:0] mirror;

  // Constant entries for angles 0 to pi/2.
  for (genvar k = 0; k <= HALF; k++) begin : g_tab
    assign tab[k] = cos_entry(k, TABLE_BITS);
  end

  assign mirror = (TABLE_BITS + 1)'(N) - idx;

  // Angles past pi/2 read the mirrored entry, negated.
  always_ff @(posedge clk) begin
    if (en) begin
      if (idx > (TABLE_BITS + 1)'(HALF)) begin
        cos_val <= -tab[mirror[TABLE_BITS-1:0]];
      end else begin
        cos_val <= tab[idx[TABLE_BITS-1:0]];
      end
    end
  end

endmodule

[rtl/vnm_octave.sv]
// One noise octave: lattice split, eight corner hashes, trilinear cosine blend, amplitude.
module vnm_octave #(
  parameter int OCT            = 0,
  parameter int COS_TABLE_BITS = vnm_pkg::COS_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               en,
  input  vnm_pkg::lane_in_t  pt,
  input  logic [16:0]        amp,
  output logic signed [31:0] contrib
);
  import vnm_pkg::*;

  localparam int EW = SPW + OCT + 32;
  localparam int SH = 20 - COS_TABLE_BITS;
  localparam int IW = COS_TABLE_BITS + 1;
  localparam logic [20:0] RND = 21'(1) << (SH - 1);

  logic [EW-1:0]             ext [3];
  logic [31:0]               q   [3];
  logic [20:0]               rfr [3];
  logic [2:0][31:0]          li;
  logic [2:0][IW-1:0]        cidx;
  logic signed [31:0]        cosv [3];
  logic [31:0]               a0;
  logic signed [32:0]        wdiff [3];
  logic [2:0][30:0]          wd [8];
  logic [31:0]               ap  [8];
  logic [31:0]               ap4 [8];
  logic [31:0]               ap5 [8];
  logic [31:0]               sq  [8];
  logic [31:0]               mm  [8];
  logic [31:0]               tt  [8];
  logic signed [31:0]        h   [8];
  logic signed [63:0]        p1  [4];
  logic signed [31:0]        b1  [4];
  logic signed [31:0]        r1  [4];
  logic signed [63:0]        p2  [2];
  logic signed [31:0]        b2  [2];
  logic signed [31:0]        r2  [2];
  logic signed [63:0]        p3;
  logic signed [31:0]        b3;
  logic signed [31:0]        val;
  logic signed [49:0]        cprod;

  // Scale by 2^OCT, split into integer and fraction, round the table index.
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      ext[ax] = EW'(pt.mag[ax]) << OCT;
      q[ax]   = ext[ax][51:20];
      rfr[ax] = {1'b0, ext[ax][19:0]} + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 3; ax++) begin
        li[ax]   <= pt.neg[ax] ? 32'd0 - q[ax] : q[ax];
        cidx[ax] <= IW'(rfr[ax] >> SH);
      end
    end
  end

  // Table reads for the three fractions.
  for (genvar ax = 0; ax < 3; ax++) begin : g_rom
    vnm_cos_rom #(
      .TABLE_BITS (COS_TABLE_BITS)
    ) u_rom (
      .clk     (clk),
      .en      (en),
      .idx     (cidx[ax]),
      .cos_val (cosv[ax])
    );
  end

  // Hash base of the low corner, in step with the table read.
  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= li[0] + li[1] * HASH_YMUL + li[2] * HASH_ZMUL;
    end
  end

  // Blend weights and the first hash mixing step for all eight corners.
  always_comb begin
    for (int ax = 0; ax < 3; ax++) begin
      wdiff[ax] = 33'(ONE30) - 33'(cosv[ax]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ax = 0; ax < 3; ax++) begin
        wd[0][ax] <= 31'(wdiff[ax] >>> 1);
      end
      for (int c = 0; c < 8; c++) begin
        ap[c] <= hash_mix(a0 + corner_off(c));
      end
      for (int s = 1; s < 8; s++) begin
        wd[s] <= wd[s-1];
      end
    end
  end

  // Hash polynomial, one multiply per stage.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      tt[c] = ap5[c] * mm[c] + HASH_C3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 8; c++) begin
        sq[c]  <= ap[c] * ap[c];
        ap4[c] <= ap[c];
        mm[c]  <= sq[c] * HASH_C1 + HASH_C2;
        ap5[c] <= ap4[c];
        h[c]   <= ONE30 - $signed({1'b0, tt[c][30:0]});
      end
    end
  end

  // Interpolate along x, then y, then z: product stage, then add stage.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        p1[j] <= blend_prod(h[2*j], h[2*j+1], wd[3][0]);
        b1[j] <= h[2*j];
        r1[j] <= blend_add(b1[j], p1[j]);
      end
      for (int j = 0; j < 2; j++) begin
        p2[j] <= blend_prod(r1[2*j], r1[2*j+1], wd[5][1]);
        b2[j] <= r1[2*j];
        r2[j] <= blend_add(b2[j], p2[j]);
      end
      p3  <= blend_prod(r2[0], r2[1], wd[7][2]);
      b3  <= r2[0];
      val <= blend_add(b3, p3);
    end
  end

  // Weight the octave value by its amplitude.
  assign cprod = 50'(val) * 50'($signed({1'b0, amp}));

  always_ff @(posedge clk) begin
    if (en) begin
      contrib <= 32'(cprod >>> 16);
    end
  end

endmodule

[rtl/value_noise_marble_shader_top.sv]
// Top level of the value-noise marble shader: config registers, pipeline, output buffer.
//
//   Port group      Direction  Handshake           Payload
//   in_*            input      in_valid/in_ready   in_item_t (x, y, z in Q12.12)
//   out_*           output     out_valid/out_ready out_item_t (red, green, blue)
//   APB (p*)        input      psel/penable        64-bit registers at 8*index
//
// One item enters per cycle while the output buffer has room. After scaling, each point
// passes the octave lanes (split, table read, three hash multiplies, three blends).
// All octaves run as parallel lanes, so the octave count does not change the rate.
// Reset empties the pipeline and the two-entry output buffer; there is no clearing pass.
// The pipeline stalls only while the output buffer is full.
module value_noise_marble_shader_top #(
  parameter int MAX_OCTAVES    = vnm_pkg::MAX_OCTAVES_DEF,
  parameter int COS_TABLE_BITS = vnm_pkg::COS_TABLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vnm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output vnm_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);
  import vnm_pkg::*;

  localparam int SL    = $clog2(MAX_OCTAVES);
  localparam int P2    = 1 << SL;
  localparam int SUMW  = 33 + SL;
  localparam int DEPTH = 21 + SL;
  localparam int XD    = 14 + SL;
  localparam int SH    = 20 - COS_TABLE_BITS;
  localparam int IW    = COS_TABLE_BITS + 1;
  localparam logic [21:0] RND = 22'(1) << (SH - 1);
  localparam logic [16:0] AMP_ONE = 17'h10000;

  // Configuration registers.
  logic [15:0] persistence;
  logic [3:0]  octave_count;
  logic [47:0] shift_xyz;
  logic [47:0] scale_xyz;
  logic [23:0] background_color;
  logic [23:0] foreground_color;
  reg_idx_t    reg_sel;

  // Pipeline control and data.
  logic                    en;
  logic [DEPTH-1:0]        vp;
  in_item_t                f1;
  logic signed [23:0]      crd [3];
  logic signed [39:0]      pr  [3];
  logic signed [27:0]      off [3];
  logic signed [SPW-1:0]   sp  [3];
  lane_in_t                pt;
  logic signed [SPW-1:0]   spx_d [XD];
  logic [16:0]             amp [MAX_OCTAVES];
  logic signed [31:0]      lane_c [MAX_OCTAVES];
  logic signed [SUMW-1:0]  tr [SL+1][P2];
  logic signed [SUMW-1:0]  sumf;
  logic signed [31:0]      sumc;
  logic signed [SPW-1:0]   spx_c1;
  logic signed [SPW-1:0]   tsum;
  logic [20:0]             uraw;
  logic [20:0]             u;
  logic [IW-1:0]           bidx;
  logic signed [32:0]      bsum;
  logic signed [31:0]      band;
  logic [30:0]             wb;
  logic signed [8:0]       dch [3];
  logic signed [41:0]      prodc [3];
  logic [7:0]              bgc [3];
  out_item_t               res;

  // Output buffer.
  logic [1:0]  count;
  logic [1:0]  count_next;
  logic        push;
  logic        pop;
  out_item_t   q0;
  out_item_t   q1;

  // APB access: always ready, register index from the 8-byte slot.
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      persistence      <= 16'd32768;
      octave_count     <= 4'd4;
      shift_xyz        <= 48'd0;
      scale_xyz        <= 48'h0100_0100_0100;
      background_color <= 24'h000000;
      foreground_color <= 24'hFFFFFF;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_sel)
        REG_PERSISTENCE: persistence      <= pwdata[15:0];
        REG_OCTAVES:     octave_count     <= pwdata[3:0];
        REG_SHIFT:       shift_xyz        <= pwdata[47:0];
        REG_SCALE:       scale_xyz        <= pwdata[47:0];
        REG_BG:          background_color <= pwdata[23:0];
        REG_FG:          foreground_color <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PERSISTENCE: prdata = 64'(persistence);
      REG_OCTAVES:     prdata = 64'(octave_count);
      REG_SHIFT:       prdata = 64'(shift_xyz);
      REG_SCALE:       prdata = 64'(scale_xyz);
      REG_BG:          prdata = 64'(background_color);
      REG_FG:          prdata = 64'(foreground_color);
      default:         prdata = 64'd0;
    endcase
  end

  // Octave amplitudes follow persistence through a registered chain.
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_amp
    if (i == 0) begin : g_first
      assign amp[i] = AMP_ONE;
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          amp[i] <= AMP_ONE >> i;
        end else begin
          amp[i] <= 17'((34'(amp[i-1]) * 34'(persistence)) >> 16);
        end
      end
    end
  end

  // The whole pipeline advances unless the output buffer is full.
  assign en       = (count != 2'd2);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[DEPTH-2:0], in_valid};
    end
  end

  // Capture the point, then scale and shift each axis.
  assign crd[0] = f1.x_coord;
  assign crd[1] = f1.y_coord;
  assign crd[2] = f1.z_coord;

  always_ff @(posedge clk) begin
    if (en) begin
      f1 <= in_data;
      for (int ax = 0; ax < 3; ax++) begin
        pr[ax]  <= 40'(crd[ax]) * 40'($signed(scale_xyz[16*ax +: 16]));
        off[ax] <= 28'($signed(shift_xyz[16*ax +: 16])) <<< 12;
        sp[ax]  <= SPW'(pr[ax]) + SPW'(off[ax]);
        pt.neg[ax] <= sp[ax][SPW-1];
        pt.mag[ax] <= sp[ax][SPW-1] ? SPW'(-sp[ax]) : SPW'(sp[ax]);
      end
      spx_d[0] <= sp[0];
      for (int k = 1; k < XD; k++) begin
        spx_d[k] <= spx_d[k-1];
      end
    end
  end

  // One lane per octave.
  for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_oct
    vnm_octave #(
      .OCT            (i),
      .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_oct (
      .clk     (clk),
      .en      (en),
      .pt      (pt),
      .amp     (amp[i]),
      .contrib (lane_c[i])
    );
  end

  // Lanes past the octave count contribute nothing.
  for (genvar j = 0; j < P2; j++) begin : g_leaf
    if (j < MAX_OCTAVES) begin : g_used
      assign tr[0][j] = (5'(j) < {1'b0, octave_count}) ? SUMW'(lane_c[j]) : '0;
    end else begin : g_pad
      assign tr[0][j] = '0;
    end
  end

  // Registered adder tree over the lanes.
  for (genvar l = 0; l < SL; l++) begin : g_tree
    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < P2; j++) begin
          if (j < (P2 >> (l + 1))) begin
            tr[l+1][j] <= tr[l][2*j] + tr[l][2*j+1];
          end else begin
            tr[l+1][j] <= '0;
          end
        end
      end
    end
  end

  assign sumf = tr[SL][0];

  // Clamp the noise sum, then add it to x and fold into one half period.
  assign tsum = SPW'(spx_c1) + SPW'(sumc >>> 10);
  assign uraw = tsum[20:0];

  always_ff @(posedge clk) begin
    if (en) begin
      if (sumf > SUMW'(ONE30)) begin
        sumc <= ONE30;
      end else if (sumf < -SUMW'(ONE30)) begin
        sumc <= -ONE30;
      end else begin
        sumc <= 32'(sumf);
      end
      spx_c1 <= spx_d[XD-1];
      u      <= (uraw > 21'h100000) ? 21'd0 - uraw : uraw;
    end
  end

  // Band cosine lookup.
  assign bidx = IW'((22'(u) + RND) >> SH);

  vnm_cos_rom #(
    .TABLE_BITS (COS_TABLE_BITS)
  ) u_band (
    .clk     (clk),
    .en      (en),
    .idx     (bidx),
    .cos_val (band)
  );

  // Mix the two colors per channel with rounding.
  assign bsum = 33'(ONE30) + 33'(band);
  assign wb   = 31'(bsum >>> 1);

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      dch[ch] = $signed({1'b0, foreground_color[8*ch +: 8]})
              - $signed({1'b0, background_color[8*ch +: 8]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int ch = 0; ch < 3; ch++) begin
        prodc[ch] <= 42'(dch[ch]) * 42'($signed({1'b0, wb})) + (42'sd1 <<< 29);
        bgc[ch]   <= background_color[8*ch +: 8];
      end
    end
  end

  assign res.red   = bgc[0] + 8'(prodc[0] >>> 30);
  assign res.green = bgc[1] + 8'(prodc[1] >>> 30);
  assign res.blue  = bgc[2] + 8'(prodc[2] >>> 30);

  // Two-entry output buffer decouples the pipeline from the consumer.
  assign push       = en && vp[DEPTH-1];
  assign pop        = out_valid && out_ready;
  assign out_valid  = (count != 2'd0);
  assign out_data   = q0;
  assign count_next = count + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      q0 <= (count == 2'd2) ? q1 : res;
      if (push && count == 2'd2) begin
        q1 <= res;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        q0 <= res;
      end else begin
        q1 <= res;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The buffer never holds more than two items.
  a_count_max: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("output buffer overflow");

  // A full buffer freezes the pipeline valids.
  a_freeze: assert property (@(posedge clk) disable iff (rst) (count == 2'd2) |=> $stable(vp))
    else $error("pipeline moved while output buffer full");

  // A pop with no push removes exactly one item.
  a_pop: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("output buffer count wrong after pop");

  // Leaving reset, the pipeline and buffer are empty.
  a_reset: assert property (@(posedge clk) $fell(rst) |-> (vp == '0 && count == 2'd0))
    else $error("pipeline not empty after reset");
`endif

endmodule

[test/value_noise_marble_shader_top_test.sv]
// Self-checking testbench for the value-noise marble shader: predicts each color and compares.
module value_noise_marble_shader_top_test;
  import vnm_pkg::*;

  localparam int OCTAVE_LIMIT = 8;
  localparam int TAB_BITS     = 10;
  localparam int TAB_N        = 1 << TAB_BITS;
  localparam int LATENCY      = 24;
  localparam logic signed [63:0] Q30 = 64'sd1 <<< 30;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  in_item_t           in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_item_t          out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [5:0]         paddr = '0;
  logic [63:0]        pwdata = '0;
  logic [63:0]        prdata;
  logic               pready;

  // Shadow copy of the configuration registers.
  logic [15:0] cfg_persistence = 16'd32768;
  logic [3:0]  cfg_octaves = 4'd4;
  logic [47:0] cfg_shift = '0;
  logic [47:0] cfg_scale = 48'd1099528405248;
  logic [23:0] cfg_bg = '0;
  logic [23:0] cfg_fg = 24'hFFFFFF;

  logic signed [31:0] cos_rom [0:TAB_N];
  out_item_t          color_queue[$];
  int                 error_count = 0;
  bit                 no_idle = 1'b0;

  value_noise_marble_shader_top i_dut (.*);

  always #1 clk = ~clk;

  // Integer Taylor cosine for x in Q.30 between 0 and pi/2.
  function automatic logic signed [63:0] taylor_cos(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        mag;
    logic signed [63:0] sum;
    x2  = (x * x) >> 30;
    mag = 64'd1 << 30;
    sum = Q30;
    for (int n = 1; n <= 10; n++) begin
      mag = ((mag * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sum = sum - $signed(mag);
      end else begin
        sum = sum + $signed(mag);
      end
    end
    if (sum > Q30) sum = Q30;
    if (sum < -Q30) sum = -Q30;
    return sum;
  endfunction

  function automatic logic signed [63:0] floor_sh(input logic signed [63:0] v, input int s);
    return v >>> s;
  endfunction

  function automatic logic signed [63:0] cos_at(input logic [63:0] u);
    logic [63:0] idx;
    idx = (u + (64'd1 << (19 - TAB_BITS))) >> (20 - TAB_BITS);
    if (idx > TAB_N) idx = TAB_N;
    return 64'(cos_rom[idx]);
  endfunction

  function automatic logic signed [63:0] lattice_value(input logic [31:0] x, input logic [31:0] y,
                                                       input logic [31:0] z);
    logic [31:0] a;
    logic [31:0] t;
    a = x + y * 32'd400 + z * 32'd160000;
    a = (a << 13) ^ a;
    t = (a * (a * a * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fffffff;
    return Q30 - 64'(t);
  endfunction

  function automatic logic signed [63:0] mix(input logic signed [63:0] h1,
                                             input logic signed [63:0] h2,
                                             input logic signed [63:0] w);
    return h1 + floor_sh((h2 - h1) * w, 30);
  endfunction

  // One octave of value noise at a Q.20 point.
  function automatic logic signed [63:0] octave_noise(input logic signed [63:0] p [3]);
    logic [31:0]        li [3];
    logic signed [63:0] wt [3];
    logic [63:0]        m;
    logic signed [63:0] h [8];
    logic signed [63:0] a;
    logic signed [63:0] b;
    for (int ax = 0; ax < 3; ax++) begin
      m = p[ax] < 0 ? 64'(-p[ax]) : 64'(p[ax]);
      li[ax] = p[ax] < 0 ? 32'(0) - 32'(m >> 20) : 32'(m >> 20);
      wt[ax] = (Q30 - cos_at(m & 64'hFFFFF)) >>> 1;
    end
    for (int c = 0; c < 8; c++) begin
      h[c] = lattice_value(li[0] + 32'(c & 1), li[1] + 32'((c >> 1) & 1),
                           li[2] + 32'((c >> 2) & 1));
    end
    a = mix(mix(h[0], h[1], wt[0]), mix(h[2], h[3], wt[0]), wt[1]);
    b = mix(mix(h[4], h[5], wt[0]), mix(h[6], h[7], wt[0]), wt[1]);
    return mix(a, b, wt[2]);
  endfunction

  // Shaded color of one point under the current register settings.
  function automatic out_item_t shade_point(input in_item_t pt);
    logic signed [63:0] sp [3];
    logic signed [63:0] fp [3];
    logic signed [63:0] sum;
    logic signed [63:0] w;
    logic signed [63:0] bg;
    logic signed [63:0] fg;
    logic [63:0]        amp;
    logic [63:0]        u;
    logic signed [23:0] crd [3];
    logic [7:0]         ch [3];
    int                 n;
    crd = '{pt.x_coord, pt.y_coord, pt.z_coord};
    for (int ax = 0; ax < 3; ax++) begin
      sp[ax] = 64'(crd[ax]) * 64'($signed(cfg_scale[16*ax +: 16]))
             + 64'($signed(cfg_shift[16*ax +: 16])) * 64'sd4096;
    end
    n = cfg_octaves > OCTAVE_LIMIT ? OCTAVE_LIMIT : int'(cfg_octaves);
    sum = 0;
    amp = 64'd65536;
    for (int i = 0; i < n; i++) begin
      for (int ax = 0; ax < 3; ax++) fp[ax] = sp[ax] <<< i;
      sum += floor_sh(octave_noise(fp) * $signed(amp), 16);
      amp = (amp * 64'(cfg_persistence)) >> 16;
    end
    if (sum > Q30) sum = Q30;
    if (sum < -Q30) sum = -Q30;
    u = 64'(sp[0] + floor_sh(sum, 10)) & 64'h1FFFFF;
    if (u > 64'h100000) u = 64'h200000 - u;
    w = (Q30 + cos_at(u)) >>> 1;
    for (int c = 0; c < 3; c++) begin
      bg = 64'(cfg_bg[8*c +: 8]);
      fg = 64'(cfg_fg[8*c +: 8]);
      ch[c] = 8'(bg + floor_sh((fg - bg) * w + (Q30 >>> 1), 30));
    end
    return '{blue: ch[2], green: ch[1], red: ch[0]};
  endfunction

  // APB write: setup cycle, then access cycle.
  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 6'(8 * idx); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_PERSISTENCE: cfg_persistence = val[15:0];
      REG_OCTAVES:     cfg_octaves = val[3:0];
      REG_SHIFT:       cfg_shift = val[47:0];
      REG_SCALE:       cfg_scale = val[47:0];
      REG_BG:          cfg_bg = val[23:0];
      REG_FG:          cfg_fg = val[23:0];
      default: ;
    endcase
  endtask

  // Stop sending, wait until all colors are back, then let the pipeline drain.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (color_queue.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // Send one point and queue its color once accepted; valid stays high for a following item.
  task automatic send_point(input in_item_t pt);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= pt;
    do @(posedge clk); while (!in_ready);
    color_queue.push_back(shade_point(pt));
  endtask

  function automatic in_item_t rand_point(input int mode);
    in_item_t p;
    p = $bits(in_item_t)'({$urandom(), $urandom(), $urandom()});
    // Most points stay near the origin so the noise varies visibly.
    if (mode == 0) begin
      p.x_coord = 24'($signed(22'($urandom())));
      p.y_coord = 24'($signed(22'($urandom())));
      p.z_coord = 24'($signed(22'($urandom())));
    end
    return p;
  endfunction

  task automatic test_extremes;
    logic signed [23:0] v [5];
    v = '{24'sh800000, 24'sh7FFFFF, 24'sh0, -24'sd1, 24'sd1};
    for (int i = 0; i < 5; i++) send_point('{z_coord: v[(i + 2) % 5], y_coord: v[(i + 1) % 5],
                                            x_coord: v[i]});
    send_point('{z_coord: 24'sh800000, y_coord: 24'sh800000, x_coord: 24'sh800000});
    send_point('{z_coord: 24'sh7FFFFF, y_coord: 24'sh7FFFFF, x_coord: 24'sh7FFFFF});
    drain();
  endtask

  // Extreme register settings, including zero and above-limit octave counts.
  task automatic test_register_extremes;
    write_reg(REG_OCTAVES, 64'd0);
    send_point(rand_point(0));
    drain();
    write_reg(REG_OCTAVES, 64'd15);
    write_reg(REG_PERSISTENCE, 64'hFFFF);
    write_reg(REG_SCALE, 64'h7FFF_7FFF_7FFF);
    write_reg(REG_SHIFT, 64'h8000_8000_8000);
    send_point(rand_point(1));
    send_point(rand_point(0));
    drain();
    write_reg(REG_PERSISTENCE, 64'd0);
    write_reg(REG_SCALE, 64'h8000_8000_8000);
    write_reg(REG_SHIFT, 64'h7FFF_7FFF_7FFF);
    write_reg(REG_BG, 64'hFFFFFF);
    write_reg(REG_FG, 64'h000000);
    send_point(rand_point(1));
    send_point(rand_point(0));
    drain();
    write_reg(REG_OCTAVES, 64'd8);
    write_reg(REG_SCALE, 64'h0);
    send_point(rand_point(0));
    drain();
  endtask

  // Random points under several random settings.
  task automatic test_random_points;
    for (int phase = 0; phase < 8; phase++) begin
      write_reg(REG_PERSISTENCE, 64'($urandom()));
      write_reg(REG_OCTAVES, 64'($urandom_range(15)));
      write_reg(REG_SHIFT, {$urandom(), $urandom()});
      write_reg(REG_SCALE, phase == 0 ? 64'd1099528405248 : {$urandom(), $urandom()});
      write_reg(REG_BG, 64'($urandom()));
      write_reg(REG_FG, 64'($urandom()));
      no_idle = (phase == 3);
      for (int i = 0; i < 200; i++) begin
        send_point(rand_point(int'($urandom_range(3) == 0)));
        // Midway through phase 5, hold off until every color is back.
        if (i == 100 && phase == 5) drain();
      end
      drain();
    end
    no_idle = 1'b0;
  endtask

  // Result checker.
  always @(posedge clk) begin
    out_item_t exp_c;
    if (!rst && out_valid && out_ready) begin
      if (color_queue.size() == 0) begin
        $error("unexpected color %h", out_data);
        error_count++;
      end else begin
        exp_c = color_queue.pop_front();
        if (out_data.red !== exp_c.red) begin
          $error("red: expected %0d actual %0d", exp_c.red, out_data.red);
          error_count++;
        end
        if (out_data.green !== exp_c.green) begin
          $error("green: expected %0d actual %0d", exp_c.green, out_data.green);
          error_count++;
        end
        if (out_data.blue !== exp_c.blue) begin
          $error("blue: expected %0d actual %0d", exp_c.blue, out_data.blue);
          error_count++;
        end
      end
    end
  end

  // Receiver stalls.
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(99) >= 8);
  end

  initial begin
    for (int k = 0; k <= TAB_N / 2; k++) begin
      cos_rom[k] = 32'(taylor_cos((64'd3373259426 * 64'(k)) / TAB_N));
    end
    for (int k = TAB_N / 2 + 1; k <= TAB_N; k++) cos_rom[k] = -cos_rom[TAB_N - k];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_register_extremes();
    test_random_points();
    drain();
    if (error_count == 0 && color_queue.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
